FILE: rtl/gpe_pkg.sv
// ----------------------------------------------------------------------------
// Genetic population engine package
// Shared widths, operation codes, register indexes and helper functions.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int POP_SIDE_DEF    = 128;
  localparam int GENOME_BITS_DEF = 64;

  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 14;
  localparam int BLK_W   = 6;
  localparam int BIT_W   = 6;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 15;
  localparam int LEN_W   = 7;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_XOVER  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MUTATE = 2'd2;

  localparam logic [CIDX_W-1:0] REG_PATTERN   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CHUNK     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BLOCKS    = 2'd2;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd3;

  localparam logic [LEN_W-1:0] CHUNK_RST     = 7'd8;
  localparam logic [LEN_W-1:0] BLOCKS_RST    = 7'd8;
  localparam logic [CNT_W-1:0] THRESHOLD_RST = 15'd11469;
  localparam logic [LEN_W-1:0] LEN_MAX       = 7'd64;

  typedef struct packed {
    logic done;
    logic fav;
  } scan_stat_t;

  // Chunk length zero acts as one, anything above 64 acts as 64.
  function automatic logic [LEN_W-1:0] eff_chunk(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = len;
    if (len == '0) r = 7'd1;
    else if (len > LEN_MAX) r = LEN_MAX;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] eff_blocks(input logic [LEN_W-1:0] cnt);
    return (cnt > LEN_MAX) ? LEN_MAX : cnt;
  endfunction

endpackage

FILE: rtl/gpe_scan.sv
// ----------------------------------------------------------------------------
// Pattern scan unit
// Walks up to block_count aligned blocks of one genome, one block per cycle,
// and reports whether any block equals the match pattern's low chunk bits.
// ----------------------------------------------------------------------------
module gpe_scan #(
  parameter int GENOME_BITS = gpe_pkg::GENOME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [GENOME_BITS-1:0]      genome,
  input  logic [gpe_pkg::CFG_W-1:0]   match_pattern,
  input  logic [gpe_pkg::LEN_W-1:0]   chunk_length,
  input  logic [gpe_pkg::LEN_W-1:0]   block_count,
  output gpe_pkg::scan_stat_t         stat
);
  import gpe_pkg::*;

  logic [GENOME_BITS-1:0] sh_r;
  logic [7:0]             pos_r;
  logic [LEN_W-1:0]       j_r;
  logic                   running_r;
  logic                   done_r;
  logic                   fav_r;

  logic [LEN_W-1:0]       c_eff;
  logic [LEN_W-1:0]       nb_eff;
  logic [GENOME_BITS-1:0] cmask;
  logic [GENOME_BITS-1:0] want;
  logic                   no_fit;
  logic                   hit;

  assign c_eff  = eff_chunk(chunk_length);
  assign nb_eff = eff_blocks(block_count);

  always_comb begin
    for (int i = 0; i < GENOME_BITS; i++) begin
      cmask[i] = (LEN_W'(i) < c_eff);
    end
  end

  assign want   = match_pattern[GENOME_BITS-1:0] & cmask;
  assign no_fit = (j_r >= nb_eff) || ((pos_r + {1'b0, c_eff}) > 8'(GENOME_BITS));
  assign hit    = ((sh_r & cmask) == want);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      fav_r     <= 1'b0;
    end else if (go) begin
      running_r <= 1'b1;
      done_r    <= 1'b0;
    end else if (running_r) begin
      if (no_fit || hit) begin
        running_r <= 1'b0;
        done_r    <= 1'b1;
        fav_r     <= !no_fit;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sh_r  <= genome;
      pos_r <= '0;
      j_r   <= '0;
    end else if (running_r) begin
      sh_r  <= sh_r >> c_eff;
      pos_r <= pos_r + {1'b0, c_eff};
      j_r   <= j_r + 7'd1;
    end
  end

  assign stat.done = done_r;
  assign stat.fav  = fav_r;

endmodule

FILE: rtl/genetic_population_engine_top.sv
// ----------------------------------------------------------------------------
// Genetic population engine
// Genome store with load, block crossover and guarded bit mutation, keeping
// a per-entry favorable flag and a running favorable count.
// ----------------------------------------------------------------------------
// After reset the block clears its favorable flags, one entry per cycle
// (16384 entries at the default size); in_stall stays high until every flag
// is clear. Words are handled one at a time. A load reads the entry, scans
// the new genome for the pattern, writes it back and registers the status;
// a mutate adds a scan of the old genome; a crossover adds a second scan and
// a second write. Each scan examines at most min(block_count,
// GENOME_BITS/chunk_length) blocks. An unused kind or an address out of range
// skips the scans and writes and goes straight to the output register. The
// pattern scan walks one block per cycle. A finished result is held in the
// output register while the next word is already accepted.
module genetic_population_engine_top #(
  parameter int POP_SIDE    = gpe_pkg::POP_SIDE_DEF,
  parameter int GENOME_BITS = gpe_pkg::GENOME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gpe_pkg::KIND_W-1:0]    in_kind,
  input  logic [gpe_pkg::ADDR_W-1:0]    in_first_addr,
  input  logic [gpe_pkg::ADDR_W-1:0]    in_second_addr,
  input  logic [gpe_pkg::BLK_W-1:0]     in_block_index,
  input  logic [gpe_pkg::BIT_W-1:0]     in_bit_index,
  input  logic [gpe_pkg::VAL_W-1:0]     in_load_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gpe_pkg::CNT_W-1:0]     out_favorable_count,
  output logic                          out_done_res,
  output logic                          out_first_favorable,
  output logic                          out_second_favorable,
  input  logic                          cfg_we,
  input  logic [gpe_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [gpe_pkg::CFG_W-1:0]     cfg_wdata
);
  import gpe_pkg::*;

  localparam int POP_TOTAL = POP_SIDE * POP_SIDE;
  localparam int DEPTH     = (POP_TOTAL > (1 << ADDR_W)) ? (1 << ADDR_W) : POP_TOTAL;
  localparam int AW        = $clog2(DEPTH);
  localparam int XS_W      = BLK_W + LEN_W;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RDA   = 4'd2;
  localparam logic [3:0] ST_RDB   = 4'd3;
  localparam logic [3:0] ST_PREP  = 4'd4;
  localparam logic [3:0] ST_MSCAN = 4'd5;
  localparam logic [3:0] ST_SCANA = 4'd6;
  localparam logic [3:0] ST_SCANB = 4'd7;
  localparam logic [3:0] ST_WRA   = 4'd8;
  localparam logic [3:0] ST_WRB   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // Configuration registers.
  logic [CFG_W-1:0] pattern_r;
  logic [LEN_W-1:0] chunk_r;
  logic [LEN_W-1:0] blocks_r;
  logic [CNT_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      chunk_r   <= CHUNK_RST;
      blocks_r  <= BLOCKS_RST;
      thresh_r  <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN:   pattern_r <= cfg_wdata;
        REG_CHUNK:     chunk_r   <= cfg_wdata[LEN_W-1:0];
        REG_BLOCKS:    blocks_r  <= cfg_wdata[LEN_W-1:0];
        REG_THRESHOLD: thresh_r  <= cfg_wdata[CNT_W-1:0];
        default:       pattern_r <= pattern_r;
      endcase
    end
  end

  // Stores.
  logic [GENOME_BITS-1:0] gmem [DEPTH];
  logic                   fmem [DEPTH];
  logic [GENOME_BITS-1:0] gmem_q;
  logic                   fmem_q;
  logic [AW-1:0]          rd_addr;
  logic                   g_we;
  logic                   f_we;
  logic [AW-1:0]          wr_addr;
  logic [GENOME_BITS-1:0] g_wdata;
  logic                   f_wdata;

  always_ff @(posedge clk) begin
    if (g_we) gmem[wr_addr] <= g_wdata;
    gmem_q <= gmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) fmem[wr_addr] <= f_wdata;
    fmem_q <= fmem[rd_addr];
  end

  // Control and item registers.
  logic [3:0]             state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [KIND_W-1:0]      kind_r;
  logic [ADDR_W-1:0]      a_r, b_r;
  logic [BLK_W-1:0]       blk_r;
  logic [BIT_W-1:0]       bit_r;
  logic [GENOME_BITS-1:0] val_r;
  logic [GENOME_BITS-1:0] ga_r, ga_nxt;
  logic                   fa_r, fa_nxt;
  logic                   fb_r, fb_nxt;
  logic [GENOME_BITS-1:0] na_r, na_nxt;
  logic [GENOME_BITS-1:0] nb_r, nb_nxt;
  logic                   nfa_r, nfa_nxt;
  logic                   nfb_r, nfb_nxt;
  logic                   f1_r, f1_nxt;
  logic                   f2_r, f2_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                   out_done_r, out_done_nxt;
  logic                   out_f1_r, out_f1_nxt;
  logic                   out_f2_r, out_f2_nxt;

  logic                   a_ok, b_ok;
  logic [LEN_W-1:0]       c_eff, nb_eff;
  logic [XS_W-1:0]        xstart;
  logic                   xon;
  logic [GENOME_BITS-1:0] xmask;
  logic [GENOME_BITS-1:0] xa, xb, flipped;
  logic                   bit_ok;
  logic                   scan_go;
  logic [GENOME_BITS-1:0] scan_g;
  scan_stat_t             scan_stat;
  logic                   old_b;

  assign a_ok    = (32'(a_r) < 32'(POP_TOTAL));
  assign b_ok    = (32'(b_r) < 32'(POP_TOTAL));
  assign c_eff   = eff_chunk(chunk_r);
  assign nb_eff  = eff_blocks(blocks_r);
  assign xstart  = XS_W'(blk_r) * XS_W'(c_eff);
  assign xon     = (LEN_W'(blk_r) < nb_eff) && (xstart < XS_W'(GENOME_BITS));
  assign bit_ok  = ({1'b0, bit_r} < LEN_W'(GENOME_BITS));
  assign flipped = ga_r ^ (GENOME_BITS'(1) << bit_r);

  always_comb begin
    for (int i = 0; i < GENOME_BITS; i++) begin
      xmask[i] = xon && (XS_W'(i) >= xstart) && (XS_W'(i) < (xstart + XS_W'(c_eff)));
    end
  end

  // Crossover uses the second genome straight from the read register.
  assign xa    = (ga_r & ~xmask) | (gmem_q & xmask);
  assign xb    = (gmem_q & ~xmask) | (ga_r & xmask);
  assign old_b = (a_r == b_r) ? nfa_r : fb_r;

  gpe_scan #(
    .GENOME_BITS (GENOME_BITS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (scan_go),
    .genome        (scan_g),
    .match_pattern (pattern_r),
    .chunk_length  (chunk_r),
    .block_count   (blocks_r),
    .stat          (scan_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    total_nxt     = total_r;
    ga_nxt        = ga_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    nfa_nxt       = nfa_r;
    nfb_nxt       = nfb_r;
    f1_nxt        = f1_r;
    f2_nxt        = f2_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cnt_nxt   = out_cnt_r;
    out_done_nxt  = out_done_r;
    out_f1_nxt    = out_f1_r;
    out_f2_nxt    = out_f2_r;
    rd_addr       = a_r[AW-1:0];
    g_we          = 1'b0;
    f_we          = 1'b0;
    wr_addr       = a_r[AW-1:0];
    g_wdata       = na_r;
    f_wdata       = nfa_r;
    scan_go       = 1'b0;
    scan_g        = na_r;

    case (state_r)
      ST_CLEAR: begin
        f_we    = 1'b1;
        wr_addr = clr_r;
        f_wdata = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == DEPTH - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RDA;
      end
      ST_RDA: begin
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        rd_addr   = b_r[AW-1:0];
        ga_nxt    = gmem_q;
        fa_nxt    = a_ok && fmem_q;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        fb_nxt    = b_ok && fmem_q;
        f1_nxt    = 1'b0;
        f2_nxt    = 1'b0;
        state_nxt = ST_OUT;
        case (kind_r)
          KIND_LOAD: begin
            f1_nxt = fa_r;
            if (a_ok) begin
              na_nxt    = val_r;
              scan_g    = val_r;
              scan_go   = 1'b1;
              state_nxt = ST_SCANA;
            end
          end
          KIND_XOVER: begin
            f1_nxt = fa_r;
            f2_nxt = b_ok && fmem_q;
            if (a_ok && b_ok) begin
              na_nxt    = xa;
              nb_nxt    = xb;
              scan_g    = xa;
              scan_go   = 1'b1;
              state_nxt = ST_SCANA;
            end
          end
          KIND_MUTATE: begin
            f1_nxt = fa_r;
            if (a_ok) begin
              scan_g    = ga_r;
              scan_go   = 1'b1;
              state_nxt = ST_MSCAN;
            end
          end
          default: begin
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_MSCAN: begin
        // A favorable genome is protected from mutation.
        if (scan_stat.done) begin
          if (scan_stat.fav) begin
            na_nxt    = ga_r;
            nfa_nxt   = 1'b1;
            state_nxt = ST_WRA;
          end else if (bit_ok) begin
            na_nxt    = flipped;
            scan_g    = flipped;
            scan_go   = 1'b1;
            state_nxt = ST_SCANA;
          end else begin
            na_nxt    = ga_r;
            nfa_nxt   = 1'b0;
            state_nxt = ST_WRA;
          end
        end
      end
      ST_SCANA: begin
        if (scan_stat.done) begin
          nfa_nxt = scan_stat.fav;
          if (kind_r == KIND_XOVER) begin
            scan_g    = nb_r;
            scan_go   = 1'b1;
            state_nxt = ST_SCANB;
          end else begin
            state_nxt = ST_WRA;
          end
        end
      end
      ST_SCANB: begin
        if (scan_stat.done) begin
          nfb_nxt   = scan_stat.fav;
          state_nxt = ST_WRA;
        end
      end
      ST_WRA: begin
        g_we      = 1'b1;
        f_we      = 1'b1;
        total_nxt = total_r + CNT_W'(nfa_r && !fa_r) - CNT_W'(fa_r && !nfa_r);
        f1_nxt    = nfa_r;
        state_nxt = (kind_r == KIND_XOVER) ? ST_WRB : ST_OUT;
      end
      ST_WRB: begin
        // With both partners the same entry, the first write already moved its flag.
        g_we      = 1'b1;
        f_we      = 1'b1;
        wr_addr   = b_r[AW-1:0];
        g_wdata   = nb_r;
        f_wdata   = nfb_r;
        total_nxt = total_r + CNT_W'(nfb_r && !old_b) - CNT_W'(old_b && !nfb_r);
        f2_nxt    = nfb_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = total_r;
          out_done_nxt  = (total_r >= thresh_r);
          out_f1_nxt    = f1_r;
          out_f2_nxt    = f2_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      kind_r <= in_kind;
      a_r    <= in_first_addr;
      b_r    <= in_second_addr;
      blk_r  <= in_block_index;
      bit_r  <= in_bit_index;
      val_r  <= in_load_value[GENOME_BITS-1:0];
    end
    ga_r      <= ga_nxt;
    fa_r      <= fa_nxt;
    fb_r      <= fb_nxt;
    na_r      <= na_nxt;
    nb_r      <= nb_nxt;
    nfa_r     <= nfa_nxt;
    nfb_r     <= nfb_nxt;
    f1_r      <= f1_nxt;
    f2_r      <= f2_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_done_r <= out_done_nxt;
    out_f1_r  <= out_f1_nxt;
    out_f2_r  <= out_f2_nxt;
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_favorable_count  = out_cnt_r;
  assign out_done_res         = out_done_r;
  assign out_first_favorable  = out_f1_r;
  assign out_second_favorable = out_f2_r;

  // The count moves only in the two store write states.
  a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_WRA && state_r != ST_WRB) |=> $stable(total_r))
    else $error("favorable count changed outside a store write");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(total_r) <= DEPTH))
    else $error("favorable count exceeds the population");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stat.done |-> (state_r == ST_MSCAN || state_r == ST_SCANA || state_r == ST_SCANB))
    else $error("pattern scan finished while nobody waits for it");

  a_wra_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRA) |=> (state_r == ST_OUT || state_r == ST_WRB))
    else $error("unexpected state after the first store write");

endmodule

FILE: bench/genetic_population_engine_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Genetic population engine testbench
// Drives loads, crossovers, mutations and unused words through the engine
// under several register settings. A predictor with its own copy of the store
// and flags computes each status word, and a monitor checks the results.
// ----------------------------------------------------------------------------
module genetic_population_engine_top_tb;
  import gpe_pkg::*;

  localparam int POP_TOTAL = POP_SIDE_DEF * POP_SIDE_DEF;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             done;
    logic             first_fav;
    logic             second_fav;
  } status_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = KIND_LOAD;
  logic [ADDR_W-1:0]   in_first_addr = '0;
  logic [ADDR_W-1:0]   in_second_addr = '0;
  logic [BLK_W-1:0]    in_block_index = '0;
  logic [BIT_W-1:0]    in_bit_index = '0;
  logic [VAL_W-1:0]    in_load_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CNT_W-1:0]    out_favorable_count;
  logic                out_done_res;
  logic                out_first_favorable;
  logic                out_second_favorable;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = REG_PATTERN;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  genetic_population_engine_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic [VAL_W-1:0] genome_copy [POP_TOTAL];
  bit               fav_copy [POP_TOTAL];
  bit               loaded [POP_TOTAL];
  int unsigned      fav_total;
  logic [63:0]      pattern_reg;
  logic [LEN_W-1:0] chunk_reg;
  logic [LEN_W-1:0] blocks_reg;
  logic [CNT_W-1:0] threshold_reg;

  status_t     pending_status [$];
  int          loaded_pool [$];
  int          mismatches;
  int          words_sent;
  int          words_checked;
  int          burst_left;
  int          idle_cycles;
  bit          hold_req;

  function automatic int chunk_eff();
    if (chunk_reg == 0) return 1;
    if (chunk_reg > 64) return 64;
    return int'(chunk_reg);
  endfunction

  function automatic int blocks_eff();
    return (blocks_reg > 64) ? 64 : int'(blocks_reg);
  endfunction

  function automatic logic [63:0] ones_below(int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic bit holds_pattern(logic [63:0] g);
    int c;
    logic [63:0] cm;
    c = chunk_eff();
    cm = ones_below(c);
    for (int j = 0; j < blocks_eff(); j++) begin
      if (j * c + c > 64) break;
      if (((g >> (j * c)) & cm) == (pattern_reg & cm)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void put_genome(int a, logic [63:0] g);
    bit nf;
    nf = holds_pattern(g);
    if (fav_copy[a] && !nf) fav_total--;
    if (!fav_copy[a] && nf) fav_total++;
    fav_copy[a] = nf;
    genome_copy[a] = g;
    if (!loaded[a]) begin
      loaded[a] = 1'b1;
      loaded_pool = {loaded_pool, a};
    end
  endfunction

  function automatic status_t predict_population_op(logic [KIND_W-1:0] kind, int a, int b,
                                                   int blk, int bitpos, logic [63:0] val);
    status_t s;
    logic [63:0] m, ga, gb;
    int c;
    s = '0;
    if (kind == KIND_LOAD) begin
      put_genome(a, val);
      s.first_fav = fav_copy[a];
    end else if (kind == KIND_XOVER) begin
      c = chunk_eff();
      m = '0;
      if (blk < blocks_eff() && blk * c < 64) m = ones_below(c) << (blk * c);
      ga = genome_copy[a];
      gb = genome_copy[b];
      put_genome(a, (ga & ~m) | (gb & m));
      put_genome(b, (gb & ~m) | (ga & m));
      s.first_fav = fav_copy[a];
      s.second_fav = fav_copy[b];
    end else if (kind == KIND_MUTATE) begin
      ga = genome_copy[a];
      if (!holds_pattern(ga)) ga[bitpos] = ~ga[bitpos];
      put_genome(a, ga);
      s.first_fav = fav_copy[a];
    end
    s.count = fav_total[CNT_W-1:0];
    s.done = (fav_total >= threshold_reg);
    return s;
  endfunction

  // Sends one word; valid stays high afterwards unless a gap follows.
  task automatic send_word(logic [KIND_W-1:0] kind, int a, int b, int blk, int bitpos,
                           logic [63:0] val);
    @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_first_addr = ADDR_W'(a);
    in_second_addr = ADDR_W'(b);
    in_block_index = BLK_W'(blk);
    in_bit_index = BIT_W'(bitpos);
    in_load_value = val;
    do @(posedge clk); while (in_stall);
    pending_status = {pending_status, predict_population_op(kind, a, b, blk, bitpos, val)};
    words_sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    idle_gap(1);
    wait (pending_status.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_PATTERN:   pattern_reg = data;
      REG_CHUNK:     chunk_reg = data[LEN_W-1:0];
      REG_BLOCKS:    blocks_reg = data[LEN_W-1:0];
      REG_THRESHOLD: threshold_reg = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [63:0] pat, int chunk, int blocks, int thr);
    write_reg(REG_PATTERN, pat);
    write_reg(REG_CHUNK, 64'(chunk));
    write_reg(REG_BLOCKS, 64'(blocks));
    write_reg(REG_THRESHOLD, 64'(thr));
  endtask

  function automatic logic [63:0] with_pattern(logic [63:0] v);
    int c, nbk, j;
    logic [63:0] cm;
    c = chunk_eff();
    cm = ones_below(c);
    nbk = (blocks_eff() < 64 / c) ? blocks_eff() : 64 / c;
    if (nbk == 0) return v;
    j = $urandom_range(0, nbk - 1);
    return (v & ~(cm << (j * c))) | ((pattern_reg & cm) << (j * c));
  endfunction

  function automatic int pool_pick();
    return loaded_pool[$urandom_range(0, loaded_pool.size() - 1)];
  endfunction

  task automatic send_random_word();
    int r, a, b, blk, nbk, c;
    logic [63:0] v;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    b = $urandom_range(0, POP_TOTAL - 1);
    c = chunk_eff();
    nbk = (blocks_eff() < 64 / c) ? blocks_eff() : 64 / c;
    blk = ($urandom_range(0, 9) < 7 && nbk > 0) ? $urandom_range(0, nbk - 1)
                                                : $urandom_range(0, 63);
    if (r < 30 || loaded_pool.size() < 2) begin
      kind = KIND_LOAD;
      a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POP_TOTAL - 1) : pool_pick();
      if ($urandom_range(0, 9) < 4) v = with_pattern(v);
    end else if (r < 65) begin
      kind = KIND_XOVER;
      a = pool_pick();
      b = ($urandom_range(0, 19) == 0) ? a : pool_pick();
    end else if (r < 95) begin
      kind = KIND_MUTATE;
      a = pool_pick();
    end else begin
      kind = KIND_SPARE;
      a = $urandom_range(0, POP_TOTAL - 1);
    end
    send_word(kind, a, b, blk, $urandom_range(0, 63), v);
    // Bursts of random length separated by random gaps.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
    end else begin
      burst_left--;
    end
  endtask

  task automatic test_directed_ops();
    set_regs(64'hFFFF_FFFF_FFFF_FFA5, 8, 8, 2);
    send_word(KIND_LOAD, 0, 16383, 0, 0, 64'h0);
    send_word(KIND_LOAD, 16383, 0, 63, 63, '1);
    send_word(KIND_LOAD, 1, 2, 0, 0, 64'hA500_0000_0000_0000);
    send_word(KIND_LOAD, 2, 1, 0, 0, 64'h0000_0000_0000_00A5);
    send_word(KIND_XOVER, 0, 1, 7, 0, '0);
    send_word(KIND_XOVER, 1, 1, 0, 0, '0);
    send_word(KIND_XOVER, 0, 2, 9, 0, '0);
    send_word(KIND_XOVER, 0, 2, 63, 0, '0);
    send_word(KIND_MUTATE, 0, 0, 0, 3, '0);
    send_word(KIND_MUTATE, 16383, 0, 0, 63, '0);
    send_word(KIND_MUTATE, 16383, 0, 0, 0, '0);
    send_word(KIND_SPARE, 5, 7, 0, 0, '1);
    send_word(KIND_LOAD, 16383, 0, 0, 0, 64'h0000_00A5_0000_0000);
    send_word(KIND_XOVER, 16383, 0, 4, 0, '0);
    send_word(KIND_MUTATE, 2, 0, 0, 5, '0);
    send_word(KIND_LOAD, 0, 0, 0, 0, '1);
    send_word(KIND_LOAD, 1, 0, 0, 0, '0);
    drain();
  endtask

  task automatic test_random_phase(logic [63:0] pat, int chunk, int blocks, int thr, int n);
    set_regs(pat, chunk, blocks, thr);
    for (int i = 0; i < n; i++) send_random_word();
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random_word();
    // Sender pauses here until every status word is back.
    drain();
    for (int i = 0; i < 60; i++) send_random_word();
    drain();
  endtask

  // Receiver stall pattern, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      idle_cycles = 0;
      while (idle_cycles < 600) begin
        @(negedge clk);
        idle_cycles++;
      end
      out_stall <= 1'b0;
    end else begin
      case (($time / 12000) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ((($time / 12) % 7) < 3);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    status_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected status word: count %0d", out_favorable_count);
      end else begin
        exp_s = pending_status.pop_front();
        words_checked++;
        if (out_favorable_count !== exp_s.count || out_done_res !== exp_s.done ||
            out_first_favorable !== exp_s.first_fav ||
            out_second_favorable !== exp_s.second_fav) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch %0d: exp cnt %0d done %0b f1 %0b f2 %0b, got %0d %0b %0b %0b",
                     words_checked, exp_s.count, exp_s.done, exp_s.first_fav, exp_s.second_fav,
                     out_favorable_count, out_done_res, out_first_favorable,
                     out_second_favorable);
        end
      end
    end
  end

  // Watchdog: counts cycles with no accepted word on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    fav_total = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    burst_left = 0;
    hold_req = 1'b0;
    pattern_reg = '0;
    chunk_reg = CHUNK_RST;
    blocks_reg = BLOCKS_RST;
    threshold_reg = THRESHOLD_RST;
    for (int i = 0; i < POP_TOTAL; i++) begin
      genome_copy[i] = '0;
      fav_copy[i] = 1'b0;
      loaded[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    test_random_phase({$urandom, $urandom}, 4, 16, 20, 250);
    test_random_phase({$urandom, $urandom}, 1, 64, 0, 200);
    test_random_phase({$urandom, $urandom}, 64, 1, 16384, 200);
    test_random_phase({$urandom, $urandom}, 0, 0, 5, 150);
    test_random_phase('1, 127, 127, 40, 150);
    test_random_phase({$urandom, $urandom}, 7, 9, 60, 250);
    test_backpressure();
    test_random_phase('0, 3, 30, 32767, 200);

    idle_gap(1);
    wait (pending_status.size() == 0);
    repeat (300) @(posedge clk);
    $display("Sent %0d words, checked %0d status words, %0d mismatches", words_sent,
             words_checked, mismatches);
    $display("Covered loads, crossovers, guarded mutations and unused words over 8 settings");
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
